### src/rtfe_pkg.sv
// ----------------------------------------------------------------------------
// rtfe_pkg
// Types, constants and helpers shared by the RTC fields to epoch seconds
// pipeline.
// ----------------------------------------------------------------------------
package rtfe_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_BCD_MODE        = 8'd0;
  localparam logic [7:0] CFG_HOUR12_MODE     = 8'd1;
  localparam logic [7:0] CFG_CENTURY_PRESENT = 8'd2;
  localparam logic [7:0] CFG_PIVOT_YEAR      = 8'd3;

  localparam logic [13:0] PIVOT_RESET = 14'd2022;
  localparam logic [6:0]  PIVOT_LO_RESET = 7'd22;
  localparam logic [13:0] PIVOT_BASE_RESET = 14'd2000;

  // floor(n / 100) = (n * DIV100_MUL) >> DIV100_SHIFT, exact for n < 32768
  localparam logic [29:0] DIV100_MUL   = 30'd20972;
  localparam int          DIV100_SHIFT = 21;

  // floor(n / 12) = (n * 171) >> 11, exact for n < 256
  localparam logic [15:0] DIV12_MUL = 16'd171;

  // days from year 0 to 1970-01-01
  localparam logic [25:0] EPOCH_DAYS = 26'd719528;
  localparam logic [41:0] SECS_PER_DAY = 42'd86400;

  typedef struct packed {
    logic        bcd_mode;
    logic        hour12_mode;
    logic        century_present;
    logic [6:0]  pivot_lo;    // pivot_year mod 100
    logic [13:0] pivot_base;  // pivot_year rounded down to a century
  } cfg_t;

  typedef struct packed {
    logic [7:0] century_raw;
    logic [7:0] year_raw;
    logic [7:0] month_raw;
    logic [7:0] day_raw;
    logic [7:0] hour_raw;
    logic [7:0] minute_raw;
    logic [7:0] second_raw;
  } raw_t;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [3:0] midx;
    logic [7:0] yr;
    logic [7:0] cent;
  } dec_t;

  typedef struct packed {
    logic [14:0] year;
    logic [7:0]  day;
    logic [3:0]  midx;
    logic [19:0] tod;
  } yr_t;

  typedef struct packed {
    logic [14:0] year;
    logic [12:0] quads;      // floor((y + 3) / 4)
    logic [8:0]  cents;      // floor((y + 99) / 100)
    logic [6:0]  quad_cents; // floor((y + 399) / 400)
    logic [8:0]  y_div100;   // floor(y / 100)
    logic [7:0]  day;
    logic [3:0]  midx;
    logic [19:0] tod;
  } div_t;

  typedef struct packed {
    logic [25:0] days;  // two's complement
    logic [19:0] tod;
  } day_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] midx, input logic leap);
    logic [8:0] base;
    logic       adj;
    unique case (midx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    adj = leap && (midx >= 4'd2);
    return base + 9'(adj);
  endfunction

endpackage

### src/rtc_fields_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// rtc_fields_to_epoch_seconds
// RTC register snapshot to signed seconds since 1970-01-01, five stages.
// ----------------------------------------------------------------------------
// Each request passes the decode, year, yeardiv, days and scale registers
// to m_tdata; the first of the five loads at the accept edge. Throughput:
// one request per cycle while m_tready is high; each stage holds one request
// and advances when the next stage has room, so bubbles fill under stall.
// Reset: rst clears all stage valid bits and sets the registers to BCD on,
// 24-hour mode, no century byte, pivot year 2022.
module rtc_fields_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // second_raw, minute_raw, hour_raw, day_raw, month_raw, year_raw, century_raw
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // epoch_seconds [40:0], zero [47:41]
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        bcd_mode;
  logic        hour12_mode;
  logic        century_present;
  logic [13:0] pivot_year;
  logic [6:0]  pivot_lo;
  logic [13:0] pivot_base;
  logic [26:0] pivot_prod;
  logic [6:0]  pivot_lo_next;

  rtfe_pkg::cfg_t cfg;
  rtfe_pkg::raw_t raw;
  rtfe_pkg::dec_t dec_data;
  rtfe_pkg::yr_t  yr_data;
  rtfe_pkg::div_t div_data;
  rtfe_pkg::day_t day_data;
  logic [40:0]    secs;

  logic dec_valid, dec_ready;
  logic yr_valid, yr_ready;
  logic div_valid, div_ready;
  logic day_valid, day_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bcd_mode        <= 1'b1;
      hour12_mode     <= 1'b0;
      century_present <= 1'b0;
      pivot_year      <= rtfe_pkg::PIVOT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtfe_pkg::CFG_BCD_MODE:        bcd_mode        <= cfg_data[0];
        rtfe_pkg::CFG_HOUR12_MODE:     hour12_mode     <= cfg_data[0];
        rtfe_pkg::CFG_CENTURY_PRESENT: century_present <= cfg_data[0];
        rtfe_pkg::CFG_PIVOT_YEAR:      pivot_year      <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // pivot window split; pivot_lo and pivot_base are registered from pivot_year and follow it in the next cycle
  always_comb begin
    pivot_prod    = 27'(pivot_year) * 27'd5243;
    pivot_lo_next = 7'(pivot_year - 14'(pivot_prod[26:19]) * 14'd100);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_lo   <= rtfe_pkg::PIVOT_LO_RESET;
      pivot_base <= rtfe_pkg::PIVOT_BASE_RESET;
    end else begin
      pivot_lo   <= pivot_lo_next;
      pivot_base <= pivot_year - 14'(pivot_lo_next);
    end
  end

  always_comb begin
    cfg.bcd_mode        = bcd_mode;
    cfg.hour12_mode     = hour12_mode;
    cfg.century_present = century_present;
    cfg.pivot_lo        = pivot_lo;
    cfg.pivot_base      = pivot_base;

    raw.second_raw  = s_tdata[7:0];
    raw.minute_raw  = s_tdata[15:8];
    raw.hour_raw    = s_tdata[23:16];
    raw.day_raw     = s_tdata[31:24];
    raw.month_raw   = s_tdata[39:32];
    raw.year_raw    = s_tdata[47:40];
    raw.century_raw = s_tdata[55:48];
  end

  rtfe_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (raw),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  rtfe_year u_year (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (yr_valid),
    .out_ready (yr_ready),
    .out_data  (yr_data)
  );

  rtfe_yeardiv u_yeardiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (yr_valid),
    .in_ready  (yr_ready),
    .in_data   (yr_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  rtfe_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (day_valid),
    .out_ready (day_ready),
    .out_data  (day_data)
  );

  rtfe_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (day_valid),
    .in_ready  (day_ready),
    .in_data   (day_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (secs)
  );

  assign m_tdata = {7'b0, secs};

endmodule

### src/rtfe_decode.sv
// ----------------------------------------------------------------------------
// rtfe_decode
// Stage 1: BCD decode, 12-hour fold and month index.
// ----------------------------------------------------------------------------
module rtfe_decode (
  input  logic          clk,
  input  logic          rst,
  input  rtfe_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  rtfe_pkg::raw_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rtfe_pkg::dec_t out_data
);

  rtfe_pkg::dec_t data_next;
  logic [7:0]  hour_bcd;
  logic [7:0]  hour_dec;
  logic [7:0]  hour_fold;
  logic [7:0]  mon_dec;
  logic [7:0]  mon_m1;
  logic [15:0] mon_prod;
  logic [7:0]  mon_rem;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    hour_bcd = rtfe_pkg::bcd_to_bin({1'b0, in_data.hour_raw[6:0]});
    if (cfg.bcd_mode) begin
      data_next.sec  = rtfe_pkg::bcd_to_bin(in_data.second_raw);
      data_next.min  = rtfe_pkg::bcd_to_bin(in_data.minute_raw);
      data_next.day  = rtfe_pkg::bcd_to_bin(in_data.day_raw);
      data_next.yr   = rtfe_pkg::bcd_to_bin(in_data.year_raw);
      data_next.cent = rtfe_pkg::bcd_to_bin(in_data.century_raw);
      mon_dec        = rtfe_pkg::bcd_to_bin(in_data.month_raw);
      // decoded low part stays below 128, so PM bit rides on top
      hour_dec       = {in_data.hour_raw[7], hour_bcd[6:0]};
    end else begin
      data_next.sec  = in_data.second_raw;
      data_next.min  = in_data.minute_raw;
      data_next.day  = in_data.day_raw;
      data_next.yr   = in_data.year_raw;
      data_next.cent = in_data.century_raw;
      mon_dec        = in_data.month_raw;
      hour_dec       = in_data.hour_raw;
    end

    // 12 AM is hour 0, PM adds 12
    hour_fold = {1'b0, hour_dec[6:0]};
    if (hour_fold == 8'd12) begin
      hour_fold = 8'd0;
    end
    if (hour_dec[7]) begin
      hour_fold = hour_fold + 8'd12;
    end
    data_next.hour = cfg.hour12_mode ? hour_fold : hour_dec;

    mon_m1   = mon_dec - 8'd1;
    mon_prod = 16'(mon_m1) * rtfe_pkg::DIV12_MUL;
    mon_rem  = mon_m1 - 8'(mon_prod[15:11]) * 8'd12;
    data_next.midx = mon_rem[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### src/rtfe_year.sv
// ----------------------------------------------------------------------------
// rtfe_year
// Stage 2: full year from century byte or pivot window, time of day in
// seconds.
// ----------------------------------------------------------------------------
module rtfe_year (
  input  logic          clk,
  input  logic          rst,
  input  rtfe_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  rtfe_pkg::dec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rtfe_pkg::yr_t out_data
);

  rtfe_pkg::yr_t data_next;
  logic [14:0]   wrap_add;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    wrap_add = (in_data.yr < 8'(cfg.pivot_lo)) ? 15'd100 : 15'd0;
    if (cfg.century_present) begin
      data_next.year = 15'(in_data.cent) * 15'd100 + 15'(in_data.yr);
    end else begin
      data_next.year = 15'(in_data.yr) + wrap_add + 15'(cfg.pivot_base);
    end
    data_next.tod  = 20'(in_data.hour) * 20'd3600 + 20'(in_data.min) * 20'd60
                   + 20'(in_data.sec);
    data_next.day  = in_data.day;
    data_next.midx = in_data.midx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### src/rtfe_yeardiv.sv
// ----------------------------------------------------------------------------
// rtfe_yeardiv
// Stage 3: leap-day quotients of the year by 4, 100 and 400.
// ----------------------------------------------------------------------------
module rtfe_yeardiv (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rtfe_pkg::yr_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rtfe_pkg::div_t out_data
);

  rtfe_pkg::div_t data_next;
  logic [14:0] n_cent;
  logic [15:0] n_quad;
  logic [15:0] n_qc;
  logic [29:0] prod_cent;
  logic [29:0] prod_qc;
  logic [29:0] prod_y;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    n_cent    = in_data.year + 15'd99;
    n_quad    = 16'(in_data.year) + 16'd3;
    n_qc      = (16'(in_data.year) + 16'd399) >> 2;
    prod_cent = 30'(n_cent) * rtfe_pkg::DIV100_MUL;
    prod_qc   = 30'(n_qc) * rtfe_pkg::DIV100_MUL;
    prod_y    = 30'(in_data.year) * rtfe_pkg::DIV100_MUL;

    data_next.year       = in_data.year;
    data_next.quads      = n_quad[14:2];
    data_next.cents      = prod_cent[29:rtfe_pkg::DIV100_SHIFT];
    data_next.quad_cents = prod_qc[27:rtfe_pkg::DIV100_SHIFT];
    data_next.y_div100   = prod_y[29:rtfe_pkg::DIV100_SHIFT];
    data_next.day        = in_data.day;
    data_next.midx       = in_data.midx;
    data_next.tod        = in_data.tod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### src/rtfe_days.sv
// ----------------------------------------------------------------------------
// rtfe_days
// Stage 4: day count since the epoch from year, leap rule, month start
// and day of month.
// ----------------------------------------------------------------------------
module rtfe_days (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rtfe_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rtfe_pkg::day_t out_data
);

  rtfe_pkg::day_t data_next;
  logic [25:0] y365;
  logic [14:0] cent_floor;
  logic        leap;
  logic [8:0]  mstart;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    cent_floor = 15'(in_data.y_div100) * 15'd100;
    leap = (in_data.year[1:0] == 2'b00) &&
           ((in_data.year != cent_floor) || (in_data.y_div100[1:0] == 2'b00));
    mstart = rtfe_pkg::month_start(in_data.midx, leap);
    y365   = 26'(in_data.year) * 26'd365;
    // modular sum, read as two's complement
    data_next.days = y365 + 26'(in_data.quads) - 26'(in_data.cents)
                   + 26'(in_data.quad_cents) - rtfe_pkg::EPOCH_DAYS
                   + 26'(mstart) + 26'(in_data.day) - 26'd1;
    data_next.tod  = in_data.tod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### src/rtfe_scale.sv
// ----------------------------------------------------------------------------
// rtfe_scale
// Stage 5: days times 86400 plus time of day, output register.
// ----------------------------------------------------------------------------
module rtfe_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rtfe_pkg::day_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [40:0]   out_data
);

  logic [41:0] days_ext;
  logic [41:0] secs;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    days_ext = {{16{in_data.days[25]}}, in_data.days};
    secs     = days_ext * rtfe_pkg::SECS_PER_DAY + 42'(in_data.tod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= secs[40:0];
    end
  end

endmodule
